// File: rtl/core/sle_pkg.sv
package sle_pkg;

   localparam int KEY_CODES = 128;
   localparam int KEY_W = $clog2(KEY_CODES);
   localparam int CHAR_W = 7;
   localparam int COUNT_W = 16;
   localparam int KIND_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_W-1:0] SC_LSHIFT = 7'h2A;
   localparam logic [KEY_W-1:0] SC_RSHIFT = 7'h36;
   localparam logic [KEY_W-1:0] SC_ENTER = 7'h1C;
   localparam logic [KEY_W-1:0] SC_BACKSPACE = 7'h0E;

   localparam logic [KIND_W-1:0] EV_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] EV_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] EV_END = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECRET_MODE = 2'd1;

   localparam logic [CSR_DATA_W-1:0] LINE_LIMIT_RESET = 16'd256;
   localparam logic [CHAR_W-1:0] CHAR_ASTERISK = 7'h2A;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
   } op_type;

   function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] c;
      unique case (key)
         7'h01: c = 7'h1B;
         7'h02: c = 7'h31;
         7'h03: c = 7'h32;
         7'h04: c = 7'h33;
         7'h05: c = 7'h34;
         7'h06: c = 7'h35;
         7'h07: c = 7'h36;
         7'h08: c = 7'h37;
         7'h09: c = 7'h38;
         7'h0A: c = 7'h39;
         7'h0B: c = 7'h30;
         7'h0C: c = 7'h2D;
         7'h0D: c = 7'h3D;
         7'h0E: c = 7'h08;
         7'h0F: c = 7'h09;
         7'h10: c = 7'h71;
         7'h11: c = 7'h77;
         7'h12: c = 7'h65;
         7'h13: c = 7'h72;
         7'h14: c = 7'h74;
         7'h15: c = 7'h79;
         7'h16: c = 7'h75;
         7'h17: c = 7'h69;
         7'h18: c = 7'h6F;
         7'h19: c = 7'h70;
         7'h1A: c = 7'h5B;
         7'h1B: c = 7'h5D;
         7'h1C: c = 7'h0A;
         7'h1E: c = 7'h61;
         7'h1F: c = 7'h73;
         7'h20: c = 7'h64;
         7'h21: c = 7'h66;
         7'h22: c = 7'h67;
         7'h23: c = 7'h68;
         7'h24: c = 7'h6A;
         7'h25: c = 7'h6B;
         7'h26: c = 7'h6C;
         7'h27: c = 7'h3B;
         7'h28: c = 7'h27;
         7'h29: c = 7'h60;
         7'h2B: c = 7'h5C;
         7'h2C: c = 7'h7A;
         7'h2D: c = 7'h78;
         7'h2E: c = 7'h63;
         7'h2F: c = 7'h76;
         7'h30: c = 7'h62;
         7'h31: c = 7'h6E;
         7'h32: c = 7'h6D;
         7'h33: c = 7'h2C;
         7'h34: c = 7'h2E;
         7'h35: c = 7'h2F;
         7'h37: c = 7'h2A;
         7'h39: c = 7'h20;
         7'h4A: c = 7'h2D;
         7'h4E: c = 7'h2B;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] shifted_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] c;
      unique case (key)
         7'h01: c = 7'h1B;
         7'h02: c = 7'h21;
         7'h03: c = 7'h40;
         7'h04: c = 7'h23;
         7'h05: c = 7'h24;
         7'h06: c = 7'h25;
         7'h07: c = 7'h5E;
         7'h08: c = 7'h26;
         7'h09: c = 7'h2A;
         7'h0A: c = 7'h28;
         7'h0B: c = 7'h29;
         7'h0C: c = 7'h5F;
         7'h0D: c = 7'h2B;
         7'h0E: c = 7'h08;
         7'h0F: c = 7'h09;
         7'h10: c = 7'h51;
         7'h11: c = 7'h57;
         7'h12: c = 7'h45;
         7'h13: c = 7'h52;
         7'h14: c = 7'h54;
         7'h15: c = 7'h59;
         7'h16: c = 7'h55;
         7'h17: c = 7'h49;
         7'h18: c = 7'h4F;
         7'h19: c = 7'h50;
         7'h1A: c = 7'h7B;
         7'h1B: c = 7'h7D;
         7'h1C: c = 7'h0A;
         7'h1E: c = 7'h41;
         7'h1F: c = 7'h53;
         7'h20: c = 7'h44;
         7'h21: c = 7'h46;
         7'h22: c = 7'h47;
         7'h23: c = 7'h48;
         7'h24: c = 7'h4A;
         7'h25: c = 7'h4B;
         7'h26: c = 7'h4C;
         7'h27: c = 7'h3A;
         7'h28: c = 7'h22;
         7'h29: c = 7'h7E;
         7'h2B: c = 7'h7C;
         7'h2C: c = 7'h5A;
         7'h2D: c = 7'h58;
         7'h2E: c = 7'h43;
         7'h2F: c = 7'h56;
         7'h30: c = 7'h42;
         7'h31: c = 7'h4E;
         7'h32: c = 7'h4D;
         7'h33: c = 7'h3C;
         7'h34: c = 7'h3E;
         7'h35: c = 7'h3F;
         7'h37: c = 7'h2A;
         7'h39: c = 7'h20;
         7'h4A: c = 7'h2D;
         7'h4E: c = 7'h2B;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/core/sle_front.sv
module sle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [7:0]          scancode,
   output logic                push,
   output sle_pkg::op_type     push_op
);
   import sle_pkg::*;

   logic [KEY_CODES-1:0] key_held_ff, key_held_in;
   logic                 lshift_ff, lshift_in;
   logic                 rshift_ff, rshift_in;
   logic [KEY_W-1:0]     key;
   logic                 release_code;
   logic [CHAR_W-1:0]    ch;

   assign key = scancode[KEY_W-1:0];
   assign release_code = scancode[7];
   assign ch = (lshift_ff || rshift_ff) ? shifted_char(key) : plain_char(key);

   always_comb begin
      key_held_in = key_held_ff;
      lshift_in = lshift_ff;
      rshift_in = rshift_ff;
      push = 1'b0;
      push_op.kind = EV_APPEND;
      push_op.ch = ch;
      if (in_accept) begin
         if (release_code) begin
            key_held_in[key] = 1'b0;
            if (key == SC_LSHIFT) lshift_in = 1'b0;
            if (key == SC_RSHIFT) rshift_in = 1'b0;
         end else if (!key_held_ff[key]) begin
            key_held_in[key] = 1'b1;
            priority if (key == SC_ENTER) begin
               push = 1'b1;
               push_op.kind = EV_END;
            end else if (key == SC_BACKSPACE) begin
               push = 1'b1;
               push_op.kind = EV_DELETE;
            end else if (key == SC_LSHIFT) begin
               lshift_in = 1'b1;
            end else if (key == SC_RSHIFT) begin
               rshift_in = 1'b1;
            end else begin
               // keys with no character still get their held mark
               push = (ch != '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_held_ff <= '0;
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
      end else begin
         key_held_ff <= key_held_in;
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
      end
   end

endmodule

// File: rtl/core/sle_queue.sv
module sle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sle_pkg::op_type     push_op,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output sle_pkg::op_type     pop_op
);
   import sle_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/sle_back.sv
module sle_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                op_valid,
   input  sle_pkg::op_type                     op,
   output logic                                op_pop,
   input  logic                                csr_write,
   input  logic [sle_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sle_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sle_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [sle_pkg::CHAR_W-1:0]          rsp_stored_char,
   output logic [sle_pkg::CHAR_W-1:0]          rsp_echo_char,
   output logic [sle_pkg::COUNT_W-1:0]         rsp_position
);
   import sle_pkg::*;

   logic [CSR_DATA_W-1:0] line_limit_ff;
   logic                  secret_mode_ff;
   logic [COUNT_W-1:0]    line_count_ff, line_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [CHAR_W-1:0]     stored_ff, echo_ff;
   logic [COUNT_W-1:0]    position_ff;
   logic                  produce;
   logic [COUNT_W-1:0]    position_new;
   logic                  line_full;

   // output register free, or its word leaves this cycle
   assign op_pop = op_valid && (!rsp_valid_ff || !rsp_stall);

   // also covers a zero limit
   assign line_full = ({1'b0, line_count_ff} + 17'd1) >= {1'b0, line_limit_ff};

   always_comb begin
      produce = 1'b0;
      line_count_in = line_count_ff;
      position_new = line_count_ff;
      unique case (op.kind)
         EV_END: begin
            produce = 1'b1;
            line_count_in = '0;
         end
         EV_DELETE: begin
            if (line_count_ff != '0) begin
               produce = 1'b1;
               line_count_in = line_count_ff - 1'b1;
               position_new = line_count_ff - 1'b1;
            end
         end
         EV_APPEND: begin
            if (!line_full) begin
               produce = 1'b1;
               line_count_in = line_count_ff + 1'b1;
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
      if (!op_pop) line_count_in = line_count_ff;

      if (op_pop) rsp_valid_in = produce;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LINE_LIMIT_RESET;
         secret_mode_ff <= 1'b0;
         line_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_LINE_LIMIT) line_limit_ff <= csr_wdata;
         if (csr_write && csr_index == CSR_SECRET_MODE) secret_mode_ff <= csr_wdata[0];
         line_count_ff <= line_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop && produce) begin
         kind_ff <= op.kind;
         position_ff <= position_new;
         if (op.kind == EV_APPEND) begin
            stored_ff <= op.ch;
            echo_ff <= secret_mode_ff ? CHAR_ASTERISK : op.ch;
         end else begin
            stored_ff <= '0;
            echo_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_stored_char = stored_ff;
   assign rsp_echo_char = echo_ff;
   assign rsp_position = position_ff;

endmodule

// File: rtl/core/scancode_line_editor_top.sv
// path: a word that yields a result is held in a queue entry, then in the rsp register
// throughput: one scancode per cycle while req_stall is low, set by the combinational
// table lookup in the front end and the registered line counter update in the back end
// a four-word queue between the two lets either side stall on its own
// reset (synchronous): held marks, shift flags, line count and queue cleared;
// line_limit returns to 256, secret_mode to 0; no clearing pass
module scancode_line_editor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_scancode,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sle_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [sle_pkg::CHAR_W-1:0]          rsp_stored_char,
   output logic [sle_pkg::CHAR_W-1:0]          rsp_echo_char,
   output logic [sle_pkg::COUNT_W-1:0]         rsp_position,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sle_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sle_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sle_pkg::*;

   logic   queue_full;
   logic   in_accept;
   logic   push;
   op_type push_op;
   logic   op_valid;
   op_type op;
   logic   op_pop;

   assign req_stall = queue_full;
   assign in_accept = req_valid && !queue_full;
   assign csr_ready = 1'b1;

   sle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .scancode  (req_scancode),
      .push      (push),
      .push_op   (push_op)
   );

   sle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (op_pop),
      .pop_valid (op_valid),
      .pop_op    (op)
   );

   sle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_stored_char (rsp_stored_char),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_position    (rsp_position)
   );

endmodule

// File: rtl/core/sle_checker.sv
module sle_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [sle_pkg::KIND_W-1:0]          rsp_event_kind,
   input logic [sle_pkg::CHAR_W-1:0]          rsp_stored_char,
   input logic [sle_pkg::CHAR_W-1:0]          rsp_echo_char,
   input logic [sle_pkg::COUNT_W-1:0]         rsp_position
);
   import sle_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_stored_char) && $stable(rsp_echo_char) && $stable(rsp_position))
      else $error("stalled result word changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EV_APPEND || rsp_event_kind == EV_DELETE
         || rsp_event_kind == EV_END))
      else $error("illegal event kind");

   a_no_char_on_edit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_APPEND |->
         rsp_stored_char == '0 && rsp_echo_char == '0)
      else $error("character on delete or end");

   a_append_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_APPEND |->
         rsp_stored_char != '0
         && (rsp_echo_char == rsp_stored_char || rsp_echo_char == CHAR_ASTERISK))
      else $error("bad appended character or echo");

endmodule

bind scancode_line_editor_top sle_checker u_sle_checker (.*);
